### sv/swing_peak_trough_confirmer_core_macros.svh
// Assertion macros used by the block's RTL (spt_tracker.sv).
// They expect the including module to have aclk and aresetn.
`ifndef SWING_PEAK_TROUGH_CONFIRMER_CORE_MACROS_SVH
`define SWING_PEAK_TROUGH_CONFIRMER_CORE_MACROS_SVH

`define SPT_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("spt assertion failed");

`define SPT_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("spt assertion failed");

`endif

### sv/spt_pkg.sv
package spt_pkg;

    localparam int PRICE_BITS      = 32;
    localparam int SUM_BITS        = PRICE_BITS + 1;
    localparam int BAR_BITS        = 32;
    localparam int OFFSET_BITS     = 8;
    localparam int CFG_INDEX_BITS  = 4;
    localparam int CFG_DATA_BITS   = 8;

    localparam logic [BAR_BITS-1:0]       MIN_BAR_INDEX = BAR_BITS'(2);
    localparam logic [OFFSET_BITS-1:0]    OFFSET_RESET  = OFFSET_BITS'(3);

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SCAN_ENABLE   = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MARKER_OFFSET = CFG_INDEX_BITS'(1);

    localparam logic KIND_PEAK   = 1'b0;
    localparam logic KIND_TROUGH = 1'b1;

    typedef struct packed {
        logic [BAR_BITS-1:0]   bar_index;
        logic [PRICE_BITS-1:0] high_price;
        logic [PRICE_BITS-1:0] low_price;
        logic [PRICE_BITS-1:0] close_price;
    } spt_bar_t;

    typedef struct packed {
        logic                  swing_kind;
        logic [BAR_BITS-1:0]   swing_bar;
        logic [PRICE_BITS-1:0] marker_price;
    } spt_swing_t;

    typedef struct packed {
        logic                   scan_enable;
        logic [OFFSET_BITS-1:0] marker_offset_ticks;
    } spt_cfg_t;

endpackage

### sv/swing_peak_trough_confirmer_core.sv
// Swing peak and trough confirmer.
// The s_ channel carries one closed price bar per beat: index, high, low
// and close in ticks. The m_ channel carries a beat for each confirmed
// swing: its kind (peak or trough), the bar holding the extreme and the
// marker price, which is the extreme plus or minus the configured offset, saturating.
// The cfg_ channel writes the enable bit (index 0) and the marker offset
// (index 1); it is always ready. The user must make writes while no bar is
// in flight; the block itself does not enforce this. A bar is held in the
// input register and evaluated against the running search state in the
// cycle after its beat; its result is loaded into the output register,
// which drives m_valid, unless that register holds a beat not being taken.
// One bar is taken every cycle while no confirming bar waits on a stalled
// output; the compare and add-or-subtract logic is a single stage.
// Reset clears both searches, starts in peak search, enables scanning and
// sets the offset to three ticks. When the receiver stalls, a pending result
// holds in the output register; bars that confirm nothing keep flowing,
// and a bar that confirms a swing waits in the input register, which drops
// s_ready until the result beat ahead of it has been taken.
module swing_peak_trough_confirmer_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  spt_pkg::spt_bar_t                     s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output spt_pkg::spt_swing_t                   m_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [spt_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [spt_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
    import spt_pkg::*;

    logic                   scan_enable_reg, scan_enable_next;
    logic [OFFSET_BITS-1:0] offset_reg,      offset_next;
    spt_cfg_t               cfg;
    logic                   bar_valid;
    spt_bar_t               bar;
    logic                   bar_taken;
    logic                   swing_valid;
    spt_swing_t             swing;
    logic                   out_busy;

    assign cfg_ready = 1'b1;

    always_comb begin
        scan_enable_next = scan_enable_reg;
        offset_next      = offset_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_SCAN_ENABLE:   scan_enable_next = cfg_data[0];
                CFG_MARKER_OFFSET: offset_next      = cfg_data[OFFSET_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_enable_reg <= 1'b1;
            offset_reg      <= OFFSET_RESET;
        end else begin
            scan_enable_reg <= scan_enable_next;
            offset_reg      <= offset_next;
        end
    end

    assign cfg.scan_enable         = scan_enable_reg;
    assign cfg.marker_offset_ticks = offset_reg;

    spt_in_reg u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .bar_valid (bar_valid),
        .bar       (bar),
        .bar_taken (bar_taken)
    );

    spt_tracker u_tracker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .bar_valid   (bar_valid),
        .bar         (bar),
        .out_busy    (out_busy),
        .bar_taken   (bar_taken),
        .swing_valid (swing_valid),
        .swing       (swing)
    );

    spt_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (bar_taken && swing_valid),
        .swing    (swing),
        .out_busy (out_busy),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

### sv/spt_in_reg.sv
module spt_in_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  spt_pkg::spt_bar_t s_data,
    output logic              bar_valid,
    output spt_pkg::spt_bar_t bar,
    input  logic              bar_taken
);
    import spt_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    spt_bar_t data_reg;
    logic     load;

    assign s_ready   = !valid_reg || bar_taken;
    assign load      = s_valid && s_ready;
    assign bar_valid = valid_reg;
    assign bar       = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (bar_taken) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= s_data;
        end
    end

endmodule

### sv/spt_tracker.sv
`include "swing_peak_trough_confirmer_core_macros.svh"

module spt_tracker (
    input  logic                aclk,
    input  logic                aresetn,
    input  spt_pkg::spt_cfg_t   cfg,
    input  logic                bar_valid,
    input  spt_pkg::spt_bar_t   bar,
    input  logic                out_busy,
    output logic                bar_taken,
    output logic                swing_valid,
    output spt_pkg::spt_swing_t swing
);
    import spt_pkg::*;

    logic                  seek_trough_reg,  seek_trough_next;
    logic [PRICE_BITS-1:0] peak_price_reg,   peak_price_next;
    logic [BAR_BITS-1:0]   peak_bar_reg,     peak_bar_next;
    logic                  peak_valid_reg,   peak_valid_next;
    logic [PRICE_BITS-1:0] peak_level_reg,   peak_level_next;
    logic [PRICE_BITS-1:0] trough_price_reg, trough_price_next;
    logic [BAR_BITS-1:0]   trough_bar_reg,   trough_bar_next;
    logic                  trough_valid_reg, trough_valid_next;
    logic [PRICE_BITS-1:0] trough_level_reg, trough_level_next;

    logic                  ignore;
    logic                  peak_take;
    logic [PRICE_BITS-1:0] peak_cand;
    logic [BAR_BITS-1:0]   peak_cand_bar;
    logic [PRICE_BITS-1:0] peak_cand_level;
    logic                  peak_hit;
    logic [SUM_BITS-1:0]   peak_sum;
    logic [PRICE_BITS-1:0] peak_marker;
    logic                  trough_take;
    logic [PRICE_BITS-1:0] trough_cand;
    logic [BAR_BITS-1:0]   trough_cand_bar;
    logic [PRICE_BITS-1:0] trough_cand_level;
    logic                  trough_hit;
    logic [SUM_BITS-1:0]   trough_diff;
    logic [PRICE_BITS-1:0] trough_marker;
    logic                  hit;
    logic                  step;

    assign ignore = !cfg.scan_enable || (bar.bar_index < MIN_BAR_INDEX);

    assign peak_take       = bar.high_price > peak_price_reg;
    assign peak_cand       = peak_take ? bar.high_price : peak_price_reg;
    assign peak_cand_bar   = peak_take ? bar.bar_index : peak_bar_reg;
    assign peak_cand_level = peak_take ? bar.low_price : peak_level_reg;
    assign peak_hit        = (peak_valid_reg || peak_take) && (bar.close_price < peak_cand_level);
    assign peak_sum        = {1'b0, peak_cand} + SUM_BITS'(cfg.marker_offset_ticks);
    assign peak_marker     = peak_sum[PRICE_BITS] ? {PRICE_BITS{1'b1}}
                                                  : peak_sum[PRICE_BITS-1:0];

    assign trough_take       = !trough_valid_reg || (bar.low_price < trough_price_reg);
    assign trough_cand       = trough_take ? bar.low_price : trough_price_reg;
    assign trough_cand_bar   = trough_take ? bar.bar_index : trough_bar_reg;
    assign trough_cand_level = trough_take ? bar.high_price : trough_level_reg;
    assign trough_hit        = bar.close_price > trough_cand_level;
    assign trough_diff       = {1'b0, trough_cand} - SUM_BITS'(cfg.marker_offset_ticks);
    assign trough_marker     = trough_diff[PRICE_BITS] ? {PRICE_BITS{1'b0}}
                                                       : trough_diff[PRICE_BITS-1:0];

    assign hit         = !ignore && (seek_trough_reg ? trough_hit : peak_hit);
    assign bar_taken   = bar_valid && (!hit || !out_busy);
    assign swing_valid = bar_valid && hit;
    assign step        = bar_taken && !ignore;

    always_comb begin
        swing.swing_kind   = seek_trough_reg ? KIND_TROUGH : KIND_PEAK;
        swing.swing_bar    = seek_trough_reg ? trough_cand_bar : peak_cand_bar;
        swing.marker_price = seek_trough_reg ? trough_marker : peak_marker;
    end

    always_comb begin
        seek_trough_next  = seek_trough_reg;
        peak_price_next   = peak_price_reg;
        peak_bar_next     = peak_bar_reg;
        peak_valid_next   = peak_valid_reg;
        peak_level_next   = peak_level_reg;
        trough_price_next = trough_price_reg;
        trough_bar_next   = trough_bar_reg;
        trough_valid_next = trough_valid_reg;
        trough_level_next = trough_level_reg;
        if (step && !seek_trough_reg) begin
            if (peak_hit) begin
                seek_trough_next  = 1'b1;
                trough_price_next = bar.low_price;
                trough_bar_next   = bar.bar_index;
                trough_level_next = bar.high_price;
                trough_valid_next = 1'b1;
                peak_price_next   = '0;
                peak_bar_next     = '0;
                peak_level_next   = '0;
                peak_valid_next   = 1'b0;
            end else begin
                peak_price_next = peak_cand;
                peak_bar_next   = peak_cand_bar;
                peak_level_next = peak_cand_level;
                peak_valid_next = peak_valid_reg || peak_take;
            end
        end else if (step) begin
            if (trough_hit) begin
                seek_trough_next  = 1'b0;
                peak_price_next   = bar.high_price;
                peak_bar_next     = bar.bar_index;
                peak_level_next   = bar.low_price;
                peak_valid_next   = 1'b1;
                trough_price_next = '0;
                trough_bar_next   = '0;
                trough_level_next = '0;
                trough_valid_next = 1'b0;
            end else begin
                trough_price_next = trough_cand;
                trough_bar_next   = trough_cand_bar;
                trough_level_next = trough_cand_level;
                trough_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seek_trough_reg  <= 1'b0;
            peak_price_reg   <= '0;
            peak_bar_reg     <= '0;
            peak_valid_reg   <= 1'b0;
            peak_level_reg   <= '0;
            trough_price_reg <= '0;
            trough_bar_reg   <= '0;
            trough_valid_reg <= 1'b0;
            trough_level_reg <= '0;
        end else begin
            seek_trough_reg  <= seek_trough_next;
            peak_price_reg   <= peak_price_next;
            peak_bar_reg     <= peak_bar_next;
            peak_valid_reg   <= peak_valid_next;
            peak_level_reg   <= peak_level_next;
            trough_price_reg <= trough_price_next;
            trough_bar_reg   <= trough_bar_next;
            trough_valid_reg <= trough_valid_next;
            trough_level_reg <= trough_level_next;
        end
    end

    `SPT_ASSERT_NOW(a_one_search_live, 1'b1, !(peak_valid_reg && trough_valid_reg))
    `SPT_ASSERT_NOW(a_trough_tracks_mode, 1'b1, seek_trough_reg == trough_valid_reg)
    `SPT_ASSERT_NEXT(a_confirm_flips_mode, bar_taken && swing_valid,
        seek_trough_reg != $past(seek_trough_reg))
    `SPT_ASSERT_NEXT(a_ignored_bar_keeps_state, bar_taken && ignore,
        $stable(seek_trough_reg) && $stable(peak_price_reg) && $stable(trough_price_reg))

endmodule

### sv/spt_out_reg.sv
module spt_out_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  spt_pkg::spt_swing_t swing,
    output logic                out_busy,
    output logic                m_valid,
    input  logic                m_ready,
    output spt_pkg::spt_swing_t m_data
);
    import spt_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    spt_swing_t data_reg;

    assign out_busy = valid_reg && !m_ready;
    assign m_valid  = valid_reg;
    assign m_data   = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= swing;
        end
    end

endmodule

### tb/swing_peak_trough_confirmer_core_tb.sv
`timescale 1ns / 1ps

module swing_peak_trough_confirmer_core_tb;
    import spt_pkg::*;

    localparam int    CYCLE_LIMIT  = 600000;
    localparam int    DRAIN_CYCLES = 4;
    localparam int    END_CYCLES   = 16;
    localparam longint PRICE_MAX   = (longint'(1) << PRICE_BITS) - 1;
    localparam longint MID_PRICE   = longint'(1) << 20;
    localparam int    CFG_INDEX_TOP = (1 << CFG_INDEX_BITS) - 1;
    localparam int    CFG_INDEX_FIRST_UNUSED = int'(CFG_MARKER_OFFSET) + 1;

    typedef enum {
        READY_ALWAYS,
        READY_COIN,
        READY_ONE_IN_EIGHT,
        READY_RARE
    } ready_mode_t;

    class swing_scoreboard;
        spt_swing_t swings_due[$];
        logic                   scan_on;
        logic [OFFSET_BITS-1:0] offset;
        logic                   seek_trough;
        logic                   peak_valid;
        logic                   trough_valid;
        logic [PRICE_BITS-1:0]  peak_price;
        logic [PRICE_BITS-1:0]  peak_level;
        logic [PRICE_BITS-1:0]  trough_price;
        logic [PRICE_BITS-1:0]  trough_level;
        logic [BAR_BITS-1:0]    peak_bar;
        logic [BAR_BITS-1:0]    trough_bar;
        int errors;
        int bars_seen;
        int bars_ignored;
        int peaks;
        int troughs;
        int saturated;
        int writes;
        int matched;

        function new();
            scan_on = 1'b1;
            offset = OFFSET_RESET;
            seek_trough = 1'b0;
            clear_peak();
            clear_trough();
            errors = 0;
            bars_seen = 0;
            bars_ignored = 0;
            peaks = 0;
            troughs = 0;
            saturated = 0;
            writes = 0;
            matched = 0;
        endfunction

        function void clear_peak();
            peak_price = '0;
            peak_bar = '0;
            peak_valid = 1'b0;
            peak_level = '0;
        endfunction

        function void clear_trough();
            trough_price = '0;
            trough_bar = '0;
            trough_valid = 1'b0;
            trough_level = '0;
        endfunction

        function void note_write(logic [CFG_INDEX_BITS-1:0] index,
                                 logic [CFG_DATA_BITS-1:0] data);
            writes++;
            if (index == CFG_SCAN_ENABLE) begin
                scan_on = data[0];
            end else if (index == CFG_MARKER_OFFSET) begin
                offset = data[OFFSET_BITS-1:0];
            end
        endfunction

        function bit note_bar(spt_bar_t b);
            spt_swing_t sw;
            logic [SUM_BITS-1:0] sum;
            bars_seen++;
            if (!scan_on || b.bar_index < MIN_BAR_INDEX) begin
                bars_ignored++;
                return 1'b0;
            end
            if (!seek_trough) begin
                if (b.high_price > peak_price) begin
                    peak_price = b.high_price;
                    peak_bar = b.bar_index;
                    peak_level = b.low_price;
                    peak_valid = 1'b1;
                end
                if (peak_valid && b.close_price < peak_level) begin
                    sum = SUM_BITS'(peak_price) + SUM_BITS'(offset);
                    sw.swing_kind = KIND_PEAK;
                    sw.swing_bar = peak_bar;
                    sw.marker_price = sum[PRICE_BITS] ? '1 : sum[PRICE_BITS-1:0];
                    if (sum[PRICE_BITS]) saturated++;
                    swings_due.push_back(sw);
                    peaks++;
                    seek_trough = 1'b1;
                    trough_price = b.low_price;
                    trough_bar = b.bar_index;
                    trough_level = b.high_price;
                    trough_valid = 1'b1;
                    clear_peak();
                end
            end else begin
                if (!trough_valid || b.low_price < trough_price) begin
                    trough_price = b.low_price;
                    trough_bar = b.bar_index;
                    trough_level = b.high_price;
                    trough_valid = 1'b1;
                end
                if (trough_valid && b.close_price > trough_level) begin
                    sw.swing_kind = KIND_TROUGH;
                    sw.swing_bar = trough_bar;
                    if (trough_price < PRICE_BITS'(offset)) begin
                        sw.marker_price = '0;
                        saturated++;
                    end else begin
                        sw.marker_price = trough_price - PRICE_BITS'(offset);
                    end
                    swings_due.push_back(sw);
                    troughs++;
                    seek_trough = 1'b0;
                    peak_price = b.high_price;
                    peak_bar = b.bar_index;
                    peak_level = b.low_price;
                    peak_valid = 1'b1;
                    clear_trough();
                end
            end
            return 1'b1;
        endfunction

        function void check_swing(spt_swing_t got);
            spt_swing_t want;
            if (swings_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected swing beat: expected none, actual kind %0d bar %h marker %h",
                         $time, got.swing_kind, got.swing_bar, got.marker_price);
                return;
            end
            want = swings_due.pop_front();
            if (got.swing_kind !== want.swing_kind) begin
                errors++;
                $display("%0t: swing_kind mismatch: expected %0d actual %0d",
                         $time, want.swing_kind, got.swing_kind);
            end
            if (got.swing_bar !== want.swing_bar) begin
                errors++;
                $display("%0t: swing_bar mismatch: expected %h actual %h",
                         $time, want.swing_bar, got.swing_bar);
            end
            if (got.marker_price !== want.marker_price) begin
                errors++;
                $display("%0t: marker_price mismatch: expected %h actual %h",
                         $time, want.marker_price, got.marker_price);
            end
            matched++;
        endfunction
    endclass

    logic                        aclk = 1'b0;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    spt_bar_t                    s_data;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    spt_swing_t                  m_data;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_INDEX_BITS-1:0]   cfg_index;
    logic [CFG_DATA_BITS-1:0]    cfg_data;

    swing_scoreboard sb;
    int          cycle_count = 0;
    ready_mode_t ready_mode = READY_ALWAYS;
    int          ready_left = 0;
    int          ready_step = 0;
    longint      walk_price;
    int          walk_span;
    logic [BAR_BITS-1:0] next_index;

    swing_peak_trough_confirmer_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_swing(m_data);
        end
    end

    always @(negedge aclk) begin
        if (ready_left == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            ready_left = $urandom_range(32, 256);
        end
        ready_left--;
        ready_step++;
        case (ready_mode)
            READY_ALWAYS: begin
                m_ready = 1'b1;
            end
            READY_COIN: begin
                m_ready = 1'($urandom_range(0, 1));
            end
            READY_ONE_IN_EIGHT: begin
                m_ready = (ready_step % 8) == 0;
            end
            default: begin
                m_ready = $urandom_range(0, 9) == 0;
            end
        endcase
    end

    function automatic logic [PRICE_BITS-1:0] clamp_price(longint v);
        if (v < 0) return '0;
        if (v > PRICE_MAX) return PRICE_BITS'(PRICE_MAX);
        return v[PRICE_BITS-1:0];
    endfunction

    function automatic spt_bar_t make_bar();
        spt_bar_t b;
        int       pick;
        longint   hi_v;
        longint   lo_v;
        pick = $urandom_range(0, 99);
        walk_price = walk_price + longint'($urandom_range(0, 2 * walk_span)) - walk_span;
        if (walk_price < 0) walk_price = 0;
        if (walk_price > PRICE_MAX) walk_price = PRICE_MAX;
        hi_v = walk_price + longint'($urandom_range(0, walk_span));
        lo_v = walk_price - longint'($urandom_range(0, walk_span));
        b.bar_index = next_index;
        next_index++;
        b.high_price = clamp_price(hi_v);
        b.low_price = clamp_price(lo_v);
        b.close_price = clamp_price(lo_v + longint'($urandom_range(0, int'(hi_v - lo_v))));
        if (pick < 5) begin
            b.bar_index = BAR_BITS'($urandom);
            b.high_price = PRICE_BITS'($urandom);
            b.low_price = PRICE_BITS'($urandom);
            b.close_price = PRICE_BITS'($urandom);
        end else if (pick < 8) begin
            b.bar_index = BAR_BITS'($urandom_range(0, 1));
        end else if (pick < 11) begin
            if ($urandom_range(0, 1)) begin
                b.close_price = clamp_price(lo_v - walk_span - 1);
            end else begin
                b.close_price = clamp_price(hi_v + walk_span + 1);
            end
        end else if (pick < 13) begin
            b.high_price = clamp_price(lo_v);
            b.low_price = clamp_price(hi_v);
        end else if (pick < 14) begin
            next_index = BAR_BITS'($urandom);
        end
        return b;
    endfunction

    task automatic send_bar(input spt_bar_t b, output bit active);
        s_data = b;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        active = sb.note_bar(b);
        @(negedge aclk);
    endtask

    task automatic bar_at(input logic [BAR_BITS-1:0] index, input logic [PRICE_BITS-1:0] hi,
                          input logic [PRICE_BITS-1:0] lo, input logic [PRICE_BITS-1:0] cl);
        spt_bar_t b;
        bit       active;
        b.bar_index = index;
        b.high_price = hi;
        b.low_price = lo;
        b.close_price = cl;
        send_bar(b, active);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_index = index;
        cfg_data = data;
        cfg_valid = 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.note_write(index, data);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic wait_drained(input int settle);
        s_valid = 1'b0;
        while (sb.swings_due.size() != 0) @(negedge aclk);
        repeat (settle) @(negedge aclk);
    endtask

    task automatic run_phase(input int active_target, input int sent_cap, input longint base,
                             input int span, input bit pause);
        int active = 0;
        int sent = 0;
        int burst = $urandom_range(1, 16);
        bit paused = 1'b0;
        bit took;
        walk_price = base;
        walk_span = span;
        while (active < active_target && sent < sent_cap) begin
            if (burst == 0) begin
                s_valid = 1'b0;
                if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(4, 12)) @(negedge aclk);
                end else begin
                    repeat ($urandom_range(1, 3)) @(negedge aclk);
                end
                burst = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 120)
                                                    : $urandom_range(1, 16);
            end
            send_bar(make_bar(), took);
            if (took) active++;
            sent++;
            burst--;
            if (pause && !paused && active >= active_target / 2) begin
                paused = 1'b1;
                wait_drained(DRAIN_CYCLES);
            end
        end
        s_valid = 1'b0;
    endtask

    initial begin
        sb = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        next_index = BAR_BITS'(100);
        walk_price = MID_PRICE;
        walk_span = 40;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Early bars, zero highs, peak and trough confirmation, saturation at both ends,
        // same-bar confirmation and equal-price boundaries.
        bar_at(0, '1, 0, 0);
        bar_at(1, '1, 0, 0);
        bar_at(2, 0, 0, 0);
        bar_at(3, 100, 90, 95);
        bar_at(4, 120, 110, 115);
        bar_at(5, 118, 100, 105);
        bar_at(6, 110, 95, 100);
        bar_at(7, 112, 96, 111);
        bar_at(8, '1, 32'hFFFF_FFF0, 32'hFFFF_FFF8);
        bar_at(9, 5, 2, 1);
        bar_at(10, 4, 1, 3);
        bar_at(11, 9, 0, 10);
        bar_at('1, 50, 40, 45);
        bar_at(32'h8000_0000, 48, 30, 39);
        bar_at(16, 20, 10, 25);
        bar_at(17, 30, 28, 5);
        bar_at(18, 40, 28, 30);
        bar_at(19, 45, 29, 31);
        bar_at(20, 45, 44, 29);
        bar_at(1, 100, 0, 0);
        bar_at(21, 46, 45, 44);
        wait_drained(DRAIN_CYCLES);

        run_phase(300, 3000, MID_PRICE, 40, 1'b0);
        wait_drained(DRAIN_CYCLES);
        write_reg(CFG_MARKER_OFFSET, 8'h00);
        run_phase(250, 3000, 0, 8, 1'b0);
        wait_drained(DRAIN_CYCLES);
        write_reg(CFG_MARKER_OFFSET, 8'hFF);
        run_phase(250, 3000, PRICE_MAX - 100, 64, 1'b0);
        wait_drained(DRAIN_CYCLES);
        run_phase(250, 3000, 200, 24, 1'b0);
        wait_drained(DRAIN_CYCLES);
        write_reg(CFG_SCAN_ENABLE, 8'hFE);
        run_phase(1, 80, MID_PRICE, 40, 1'b0);
        wait_drained(DRAIN_CYCLES);
        write_reg(CFG_INDEX_BITS'($urandom_range(CFG_INDEX_FIRST_UNUSED, CFG_INDEX_TOP)),
                  CFG_DATA_BITS'($urandom));
        write_reg(CFG_SCAN_ENABLE, 8'h01);
        run_phase(250, 3000, MID_PRICE, 40, 1'b0);
        wait_drained(DRAIN_CYCLES);
        write_reg(CFG_MARKER_OFFSET, CFG_DATA_BITS'($urandom_range(1, 254)));
        run_phase(300, 3000, MID_PRICE, 16, 1'b1);
        wait_drained(DRAIN_CYCLES);
        write_reg(CFG_MARKER_OFFSET, CFG_DATA_BITS'(OFFSET_RESET));
        run_phase(150, 3000, longint'($urandom), 1000, 1'b0);
        wait_drained(END_CYCLES);

        $display("Sent %0d bars (%0d ignored) over %0d register writes; checked %0d swings.",
                 sb.bars_seen, sb.bars_ignored, sb.writes, sb.matched);
        $display("Confirmed %0d peaks and %0d troughs, %0d with a saturated marker.",
                 sb.peaks, sb.troughs, sb.saturated);
        if (sb.errors == 0 && sb.swings_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

### filelist.f
+incdir+sv
sv/spt_pkg.sv
sv/spt_in_reg.sv
sv/spt_tracker.sv
sv/spt_out_reg.sv
sv/swing_peak_trough_confirmer_core.sv
tb/swing_peak_trough_confirmer_core_tb.sv
